// File: hdl/crcpf_pkg.sv
// ----------------------------------------------------------------------------
// crcpf_pkg
// Types, constants and the CRC-16 byte fold shared by the packet framer.
// ----------------------------------------------------------------------------
`default_nettype none

package crcpf_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Input word as held in the input register, plus the CRC of the address
  // byte alone (a header always starts from a cleared CRC).
  typedef struct packed {
    logic        kind;
    logic [7:0]  address;
    logic [7:0]  command;
    logic [7:0]  payload_byte;
    logic        last;
    logic        append_checksum;
    logic [15:0] addr_crc;
  } stage_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
  } out_word_t;

  // One byte into the CRC, MSB first, eight shift/xor steps.
  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/crcpf_item_if.sv
// ----------------------------------------------------------------------------
// crcpf_item_if
// Input channel of the framer: header or payload word with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface crcpf_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] address;
  logic [7:0] command;
  logic [7:0] payload_byte;
  logic       last;
  logic       append_checksum;

  modport source (
    output valid, kind, address, command, payload_byte, last, append_checksum,
    input  ready
  );
  modport sink (
    input  valid, kind, address, command, payload_byte, last, append_checksum,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/crcpf_byte_if.sv
// ----------------------------------------------------------------------------
// crcpf_byte_if
// Output channel of the framer: one packet byte per word with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface crcpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_packet;

  modport source (output valid, out_byte, end_of_packet, input ready);
  modport sink   (input  valid, out_byte, end_of_packet, output ready);
endinterface

`default_nettype wire

// File: hdl/crcpf_in_stage.sv
// ----------------------------------------------------------------------------
// crcpf_in_stage
// Input register. Also folds the address byte into a cleared CRC so the
// emit stage only has one byte fold in its path.
// ----------------------------------------------------------------------------
`default_nettype none

module crcpf_in_stage
  import crcpf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  crcpf_item_if.sink   in_if,
  output      logic    stg_vld,
  output      stage_t  stg,
  input  wire logic    stg_take
);

  logic   vld_r, vld_nxt;
  stage_t stg_r;
  logic   accept;

  assign in_if.ready = !vld_r || stg_take;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (stg_take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r.kind            <= in_if.kind;
      stg_r.address         <= in_if.address;
      stg_r.command         <= in_if.command;
      stg_r.payload_byte    <= in_if.payload_byte;
      stg_r.last            <= in_if.last;
      stg_r.append_checksum <= in_if.append_checksum;
      stg_r.addr_crc        <= crc_fold(CRC_INIT, in_if.address);
    end
  end

  assign stg_vld = vld_r;
  assign stg     = stg_r;

endmodule

`default_nettype wire

// File: hdl/crcpf_emit.sv
// ----------------------------------------------------------------------------
// crcpf_emit
// CRC update and result buffer. A staged word is expanded into up to four
// packet bytes, which are then sent one per output word.
// ----------------------------------------------------------------------------
`default_nettype none

module crcpf_emit
  import crcpf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    stg_vld,
  input  wire stage_t  stg,
  output      logic    stg_take,
  crcpf_byte_if.source out_if
);

  logic [15:0] crc_r, crc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  idx_r, idx_nxt;
  out_word_t   buf_r [4];

  logic        pop, is_hdr, app, eod;
  logic [15:0] crc_mid, crc_new;
  logic [7:0]  fold_byte;
  logic [2:0]  ld_cnt;
  out_word_t   ld_buf [4];

  assign out_if.valid         = (cnt_r != 3'd0);
  assign out_if.out_byte      = buf_r[idx_r].out_byte;
  assign out_if.end_of_packet = buf_r[idx_r].end_of_packet;

  assign pop      = out_if.valid && out_if.ready;
  // load when the buffer is empty or its last word leaves this cycle
  assign stg_take = stg_vld && ((cnt_r == 3'd0) || (cnt_r == 3'd1 && pop));

  assign is_hdr    = (stg.kind == KIND_HEADER);
  assign app       = stg.last && stg.append_checksum;
  assign eod       = stg.last && !stg.append_checksum;
  assign crc_mid   = is_hdr ? stg.addr_crc : crc_r;
  assign fold_byte = is_hdr ? stg.command : stg.payload_byte;
  assign crc_new   = crc_fold(crc_mid, fold_byte);

  always_comb begin
    if (is_hdr) begin
      ld_buf[0] = '{out_byte: stg.address,   end_of_packet: 1'b0};
      ld_buf[1] = '{out_byte: stg.command,   end_of_packet: eod};
      ld_buf[2] = '{out_byte: crc_new[15:8], end_of_packet: 1'b0};
      ld_buf[3] = '{out_byte: crc_new[7:0],  end_of_packet: 1'b1};
      ld_cnt    = app ? 3'd4 : 3'd2;
    end else begin
      ld_buf[0] = '{out_byte: stg.payload_byte, end_of_packet: eod};
      ld_buf[1] = '{out_byte: crc_new[15:8],    end_of_packet: 1'b0};
      ld_buf[2] = '{out_byte: crc_new[7:0],     end_of_packet: 1'b1};
      ld_buf[3] = '{out_byte: crc_new[7:0],     end_of_packet: 1'b1};
      ld_cnt    = app ? 3'd3 : 3'd1;
    end
  end

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (stg_take) begin
      crc_nxt = crc_new;
      cnt_nxt = ld_cnt;
      idx_nxt = 2'd0;
    end else if (pop) begin
      cnt_nxt = cnt_r - 3'd1;
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_take) begin
      buf_r <= ld_buf;
    end
  end

endmodule

`default_nettype wire

// File: hdl/crc16_packet_framer.sv
// ----------------------------------------------------------------------------
// crc16_packet_framer
// Frames command packets into a byte stream with an optional CRC-16
// (poly 0x1021, init 0, MSB first) appended after the last item.
//
//   channel  dir  handshake     payload
//   in_if    in   valid/ready   kind, address, command, payload_byte,
//                               last, append_checksum
//   out_if   out  valid/ready   out_byte, end_of_packet
//
// An input word is registered, then expanded into 1 to 4 output bytes in the
// result buffer; out_if sends one byte per cycle while ready is high, so an
// item takes as many output words as it has bytes (1 for a plain payload
// byte, 4 for a header with CRC). An accepted word passes the input register
// and then the result buffer. Synchronous active-low reset clears the CRC and
// empties both stages. The input register takes a new word while the buffer
// still drains its last byte, so back-pressure reaches in_if one word later.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_packet_framer
  import crcpf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  crcpf_item_if.sink   in_if,
  crcpf_byte_if.source out_if
);

  logic   stg_vld;
  logic   stg_take;
  stage_t stg;

  crcpf_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .stg_vld  (stg_vld),
    .stg      (stg),
    .stg_take (stg_take)
  );

  crcpf_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .stg_vld  (stg_vld),
    .stg      (stg),
    .stg_take (stg_take),
    .out_if   (out_if)
  );

endmodule

`default_nettype wire
